// File: rtl/core/bba_pkg.sv
package bba_pkg;

  // Field widths
  localparam int IDX_W  = 7;
  localparam int CNT_W  = 8;
  localparam int WORD_W = 8;
  // Word counter width: covers ceil(255 / 8) = 32 words
  localparam int NW_W   = 6;

  // Request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Formatted store: block 0 used, all others free (MSB-first in each word)
  localparam logic [WORD_W-1:0] WORD0_RESET = 8'h7F;
  localparam logic [WORD_W-1:0] WORD_RESET  = 8'hFF;
  localparam logic [WORD_W-1:0] MSB_MASK    = 8'h80;

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 8'd128;

  // Command queue depth
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_CHECK,
    OP_RANGE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] lim;
  } cmd_t;

endpackage

// File: rtl/core/bba_if.sv
interface bba_req_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, req_type, block_index, input ready);
  modport sink   (input valid, req_type, block_index, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [IDX_W-1:0] result_index;
  logic             was_free;
  logic [CNT_W-1:0] free_count;

  modport source (output valid, status, result_index, was_free, free_count, input ready);
  modport sink   (input valid, status, result_index, was_free, free_count, output ready);
endinterface

// File: rtl/core/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/bba_front.sv
module bba_front import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 128
) (
  bba_req_if.sink          req,
  input  logic [CNT_W-1:0] block_count,
  input  logic             clearing,
  output logic             push_valid,
  input  logic             push_ready,
  output cmd_t             push_data
);

  localparam int CAP = (MAX_BLOCKS < 255) ? MAX_BLOCKS : 255;
  localparam logic [CNT_W-1:0] CAP_LIM = CAP[CNT_W-1:0];

  logic [CNT_W-1:0] lim;
  logic             in_range;

  // Clamp the managed block count to the store size
  assign lim      = (block_count > CAP_LIM) ? CAP_LIM : block_count;
  assign in_range = {1'b0, req.block_index} < lim;

  // Hold off items while the store is being formatted
  assign req.ready  = push_ready & ~clearing;
  assign push_valid = req.valid & ~clearing;

  // Classify the request
  always_comb begin
    push_data.idx = req.block_index;
    push_data.lim = lim;
    case (req.req_type)
      REQ_ALLOC: push_data.op = OP_ALLOC;
      REQ_FREE:  push_data.op = in_range ? OP_FREE : OP_RANGE;
      default:   push_data.op = in_range ? OP_CHECK : OP_RANGE;
    endcase
  end

endmodule

// File: rtl/core/bba_queue.sv
module bba_queue import bba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam logic [PW:0]   FULL  = (PW + 1)'(QDEPTH);
  localparam logic [PW-1:0] LAST  = PW'(QDEPTH - 1);

  cmd_t          slot [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != FULL);
  assign pop_valid  = (fill != '0);
  assign pop_data   = slot[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/core/bba_back.sv
module bba_back import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  cmd_t      pop_data,
  output logic      clearing,
  bba_rsp_if.source rsp
);

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_REPORT
  } state_t;

  state_t           state;
  logic [AW-1:0]    clr_ptr;
  cmd_t             cmd;
  logic [NW_W-1:0]  nw;
  logic [NW_W-1:0]  rd_ptr;
  logic             d_valid;
  logic [NW_W-1:0]  d_word;
  logic [CNT_W-1:0] cnt;
  logic             found;
  logic [CNT_W-1:0] found_idx;
  logic             wf;
  logic [AW-1:0]    tgt_word;
  logic [WORD_W-1:0] tgt_data;
  logic [2:0]       tgt_bit;

  logic             out_valid;
  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_index;
  logic             out_wf;
  logic [CNT_W-1:0] out_count;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] rd_data;

  logic [3:0]       cnt_add;
  logic             any_cand;
  logic [2:0]       hit_bit;
  logic             alloc_ok;
  logic [WORD_W-1:0] bit_mask;

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (AW'(rd_ptr)),
    .rd_data (rd_data)
  );

  assign clearing  = (state == S_CLEAR);
  assign pop_ready = (state == S_IDLE);
  assign alloc_ok  = found && (found_idx != '0);
  assign bit_mask  = MSB_MASK >> tgt_bit;

  // Count free blocks in the word and find the first allocatable one
  always_comb begin
    logic [8:0] j;
    logic       in_lim;
    logic       free_b;
    cnt_add  = '0;
    any_cand = 1'b0;
    hit_bit  = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      j      = {d_word, 3'(b)};
      in_lim = j < {1'b0, cmd.lim};
      free_b = rd_data[3'(WORD_W - 1 - b)];
      cnt_add = cnt_add + 4'(free_b & in_lim);
      if (free_b && in_lim && (j >= {2'b0, cmd.idx})) begin
        any_cand = 1'b1;
        hit_bit  = 3'(b);
      end
    end
  end

  // Select the map write: format pass or read-modify-write of one word
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tgt_word;
    ram_wdata = tgt_data;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ptr;
        ram_wdata = (clr_ptr == '0) ? WORD0_RESET : WORD_RESET;
      end
      S_WRITE: begin
        if (cmd.op == OP_FREE) begin
          ram_we    = 1'b1;
          ram_wdata = tgt_data | bit_mask;
        end else if (cmd.op == OP_ALLOC && alloc_ok) begin
          ram_we    = 1'b1;
          ram_wdata = tgt_data & ~bit_mask;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Sequencer: state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_ptr   <= '0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded below
      if (rsp.ready && state != S_REPORT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop_valid) begin
            cmd     <= pop_data;
            nw      <= NW_W'(({1'b0, pop_data.lim} + 9'd7) >> 3);
            rd_ptr  <= '0;
            d_valid <= 1'b0;
            cnt     <= '0;
            found   <= 1'b0;
            wf      <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue the next word read
          if (rd_ptr < nw) begin
            rd_ptr  <= rd_ptr + 1'b1;
            d_word  <= rd_ptr;
            d_valid <= 1'b1;
          end else begin
            d_valid <= 1'b0;
            if (!d_valid) begin
              state <= S_WRITE;
            end
          end
          // Consume the word read last cycle
          if (d_valid) begin
            cnt <= cnt + CNT_W'(cnt_add);
            if (cmd.op == OP_ALLOC) begin
              if (!found && any_cand) begin
                found     <= 1'b1;
                found_idx <= CNT_W'({d_word, hit_bit});
                tgt_word  <= AW'(d_word);
                tgt_data  <= rd_data;
                tgt_bit   <= hit_bit;
              end
            end else if (d_word == NW_W'(cmd.idx[IDX_W-1:3])) begin
              tgt_word <= AW'(d_word);
              tgt_data <= rd_data;
              tgt_bit  <= cmd.idx[2:0];
              wf       <= rd_data[3'(WORD_W - 1) - cmd.idx[2:0]];
            end
          end
        end
        S_WRITE: begin
          if (cmd.op == OP_ALLOC && alloc_ok) begin
            cnt <= cnt - 1'b1;
          end else if (cmd.op == OP_FREE && !wf) begin
            cnt <= cnt + 1'b1;
          end
          state <= S_REPORT;
        end
        S_REPORT: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_count <= cnt;
            out_index <= (cmd.op == OP_ALLOC && alloc_ok) ? found_idx[IDX_W-1:0] : cmd.idx;
            case (cmd.op)
              OP_ALLOC: begin
                out_status <= alloc_ok ? ST_OK : ST_NONE;
                out_wf     <= alloc_ok;
              end
              OP_FREE, OP_CHECK: begin
                out_status <= ST_OK;
                out_wf     <= wf;
              end
              default: begin
                out_status <= ST_RANGE;
                out_wf     <= 1'b0;
              end
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_index = out_index;
  assign rsp.was_free     = out_wf;
  assign rsp.free_count   = out_count;

endmodule

// File: rtl/core/block_bitmap_allocator.sv
// Each item is served by a word-by-word scan of ceil(min(block_count, MAX_BLOCKS) / 8)
// bitmap words through the single read port of the map RAM (recount on every item);
// a new item enters the scan only once the last one has been reported, while the
// command queue holds up to QDEPTH (2) more.
// Reset: synchronous; the map is formatted by a pass over ceil(MAX_BLOCKS / 8)
// words (16 by default) during which no item is accepted.
module block_bitmap_allocator import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 128
) (
  input  logic             clk,
  input  logic             rst,
  bba_req_if.sink          req,
  bba_rsp_if.source        rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] block_count;
  logic             clearing;
  logic             push_valid;
  logic             push_ready;
  cmd_t             push_data;
  logic             pop_valid;
  logic             pop_ready;
  cmd_t             pop_data;

  // Block count register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RESET;
    end else if (cfg_we) begin
      block_count <= cfg_data;
    end
  end

  bba_front #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_front (
    .req         (req),
    .block_count (block_count),
    .clearing    (clearing),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  bba_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bba_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .clearing  (clearing),
    .rsp       (rsp)
  );

  // Free count never exceeds the managed block count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.free_count <= block_count))
    else $error("free count above block count");

  // Failed requests never report a free block
  a_fail_not_free: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> !rsp.was_free)
    else $error("failed request reports a free block");

  // No item enters and no result is offered while the map is being formatted
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(req.valid && req.ready) && !rsp.valid)
    else $error("activity during format pass");

endmodule

// File: sim/block_bitmap_allocator_chk.sv
module block_bitmap_allocator_chk import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 128
) (
  input  logic             clk,
  input  logic             rst,
  bba_req_if               req,
  bba_rsp_if               rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  output int unsigned      mismatches,
  output int unsigned      results_owed
);

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] result_index;
    logic             was_free;
    logic [CNT_W-1:0] free_count;
  } alloc_result_t;

  // Shadow state: bit i set means block i is free
  logic [MAX_BLOCKS-1:0] free_map;
  logic [CNT_W-1:0]      block_limit;
  alloc_result_t         owed_results[$];

  // Apply one request to the shadow map and return the result it must produce
  function automatic alloc_result_t serve_request(logic [1:0] kind, logic [IDX_W-1:0] idx);
    alloc_result_t r;
    int live;
    int i;
    int n;
    live = (block_limit > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_limit);
    r.status       = ST_OK;
    r.result_index = idx;
    r.was_free     = 1'b0;
    if (kind == REQ_ALLOC) begin
      // Scan upward for the first free block; block 0 counts as none found
      i = int'(idx);
      while (i < live && !free_map[i]) i++;
      if (i >= live || i == 0) begin
        r.status = ST_NONE;
      end else begin
        free_map[i]    = 1'b0;
        r.result_index = i[IDX_W-1:0];
        r.was_free     = 1'b1;
      end
    end else if (int'(idx) >= live) begin
      r.status = ST_RANGE;
    end else begin
      // Free and check report the old bit; any other code leaves the map alone
      r.was_free = free_map[idx];
      if (kind == REQ_FREE) free_map[idx] = 1'b1;
    end
    n = 0;
    for (i = 0; i < live; i++) begin
      if (free_map[i]) n++;
    end
    r.free_count = (n > 255) ? 8'd255 : n[CNT_W-1:0];
    return r;
  endfunction

  task automatic flag_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Track config, compare results in order, queue predictions
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      free_map    = '1;
      free_map[0] = 1'b0;
      block_limit = BLOCK_COUNT_RESET;
      mismatches  = 0;
      owed_results.delete();
    end else begin
      if (cfg_we) block_limit = cfg_data;
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none pending: expected none, got status %0d index %0d",
                   $time, rsp.status, rsp.result_index);
        end else begin
          want = owed_results.pop_front();
          flag_field("status", 8'(want.status), 8'(rsp.status));
          flag_field("result_index", 8'(want.result_index), 8'(rsp.result_index));
          flag_field("was_free", 8'(want.was_free), 8'(rsp.was_free));
          flag_field("free_count", want.free_count, rsp.free_count);
        end
      end
      if (req.valid && req.ready) begin
        owed_results.push_back(serve_request(req.req_type, req.block_index));
      end
    end
    results_owed <= owed_results.size();
  end

endmodule

// File: sim/block_bitmap_allocator_tb.sv
module block_bitmap_allocator_tb;
  import bba_pkg::*;

  localparam int         MAX_BLOCKS   = 128;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         QUIET_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 40;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;
  logic             idle_on;
  logic             hold_off_req;
  logic [CNT_W-1:0] cur_count;
  int unsigned      mismatches;
  int unsigned      results_owed;
  int unsigned      quiet_cycles = 0;

  bba_req_if req_ch();
  bba_rsp_if rsp_ch();

  block_bitmap_allocator #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  block_bitmap_allocator_chk #(.MAX_BLOCKS(MAX_BLOCKS)) chk (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // End the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("block_bitmap_allocator_tb: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= !(idle_on && $urandom_range(0, 99) < 10);
    end
  end

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_request(logic [1:0] kind, logic [IDX_W-1:0] idx);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) < 10) ? $urandom_range(1, 30) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.block_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drain all outstanding results, then write the block count
  task automatic set_block_count(logic [CNT_W-1:0] value);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_data  <= value;
    cur_count = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random mix of requests, alloc_pct percent allocations, indices mostly in range
  task automatic run_phase(int items, int alloc_pct);
    int live;
    int roll;
    logic [1:0] kind;
    logic [IDX_W-1:0] idx;
    live = (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(cur_count);
    repeat (items) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) kind = REQ_ALLOC;
      else if (roll < alloc_pct + (100 - alloc_pct) / 2) kind = REQ_FREE;
      else if (roll < 94) kind = REQ_CHECK;
      else kind = REQ_UNUSED;
      roll = $urandom_range(0, 99);
      if (live == 0 || roll < 12) idx = IDX_W'($urandom_range(0, 127));
      else if (kind == REQ_ALLOC && roll < 60) idx = IDX_W'($urandom_range(1, 15) % live);
      else idx = IDX_W'($urandom_range(0, live - 1));
      send_request(kind, idx);
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_data           <= BLOCK_COUNT_RESET;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_ALLOC;
    req_ch.block_index <= '0;
    idle_on      = 1'b1;
    hold_off_req = 1'b0;
    cur_count    = BLOCK_COUNT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Formatted store: block 0 used, top block free
    send_request(REQ_CHECK, 7'd0);
    send_request(REQ_CHECK, 7'd127);
    send_request(REQ_ALLOC, 7'd0);
    send_request(REQ_ALLOC, 7'd127);
    // Nothing free above the start
    send_request(REQ_ALLOC, 7'd127);
    // Free block 0, then an allocate that lands on it reports none
    send_request(REQ_FREE, 7'd0);
    send_request(REQ_ALLOC, 7'd0);
    send_request(REQ_CHECK, 7'd0);
    // Free a used block, then free it again
    send_request(REQ_FREE, 7'd1);
    send_request(REQ_FREE, 7'd1);
    send_request(REQ_UNUSED, 7'd5);
    send_request(REQ_ALLOC, 7'd64);

    // Single block: out-of-range start and targets
    set_block_count(8'd1);
    send_request(REQ_ALLOC, 7'd0);
    send_request(REQ_ALLOC, 7'd5);
    send_request(REQ_CHECK, 7'd1);
    send_request(REQ_FREE, 7'd127);

    // Two blocks: take the last free one, then find none left
    set_block_count(8'd2);
    send_request(REQ_ALLOC, 7'd1);
    send_request(REQ_ALLOC, 7'd1);

    // No blocks at all
    set_block_count(8'd0);
    send_request(REQ_CHECK, 7'd0);
    send_request(REQ_ALLOC, 7'd0);
    send_request(REQ_FREE, 7'd0);
    send_request(REQ_UNUSED, 7'd127);

    // Count above the map size acts as the full map
    set_block_count(8'd255);
    send_request(REQ_CHECK, 7'd127);
    send_request(REQ_ALLOC, 7'd100);

    // Random phases across several block counts
    set_block_count(BLOCK_COUNT_RESET);
    run_phase(180, 70);
    idle_on = 1'b0;
    set_block_count(8'd255);
    run_phase(60, 50);
    idle_on = 1'b1;
    set_block_count(8'd16);
    hold_off_req = 1'b1;
    run_phase(70, 60);
    set_block_count(8'd9);
    run_phase(60, 55);
    set_block_count(8'd1);
    run_phase(30, 40);
    set_block_count(8'd0);
    run_phase(20, 40);
    set_block_count(8'd100);
    run_phase(90, 55);
    set_block_count(8'd3);
    run_phase(40, 55);
    set_block_count(8'd128);
    run_phase(100, 45);

    // Drain and give the verdict
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("block_bitmap_allocator_tb: done, clean");
    end else begin
      $display("block_bitmap_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule
